// File: rtl/jsv_pkg.sv
// Shared types, codes and literal tables for the JSON scalar validator.
// Depends on nothing; every module of the block imports it.
package jsv_pkg;

   typedef enum logic [3:0] {
      PH_LEAD,
      PH_LIT,
      PH_LIT_DONE,
      PH_SIGN,
      PH_ZERO,
      PH_INT,
      PH_DOT,
      PH_FRAC,
      PH_EXP,
      PH_EXP_SIGN,
      PH_EXP_DIG,
      PH_DECIDED,
      PH_TRAIL
   } jsv_phase_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_EXPECT,
      ST_INVALID,
      ST_NOT_SINGULAR
   } jsv_status_type;

   localparam logic [1:0] KIND_NULL   = 2'd0;
   localparam logic [1:0] KIND_FALSE  = 2'd1;
   localparam logic [1:0] KIND_TRUE   = 2'd2;
   localparam logic [1:0] KIND_NUMBER = 2'd3;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_ONE   = 8'h31;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_E_LO  = 8'h65;
   localparam logic [7:0] CH_E_UP  = 8'h45;
   localparam logic [7:0] CH_N     = 8'h6E;
   localparam logic [7:0] CH_F     = 8'h66;
   localparam logic [7:0] CH_T     = 8'h74;

   typedef struct packed {
      jsv_phase_type  phase;
      logic [2:0]     lit_pos;
      logic [1:0]     lit_choice;
      jsv_status_type status;
      logic [1:0]     kind;
      logic           second_seen;
   } jsv_state_type;

   typedef struct packed {
      logic           valid;
      jsv_status_type status;
      logic [1:0]     kind;
   } jsv_result_type;

   localparam jsv_state_type JSV_STATE_RESET = '{
      phase:       PH_LEAD,
      lit_pos:     3'd0,
      lit_choice:  2'd0,
      status:      ST_OK,
      kind:        KIND_NULL,
      second_seen: 1'b0
   };

   function automatic logic [2:0] lit_len(input logic [1:0] choice);
      unique case (choice)
         KIND_NULL:  lit_len = 3'd4;
         KIND_FALSE: lit_len = 3'd5;
         KIND_TRUE:  lit_len = 3'd4;
         default:    lit_len = 3'd0;
      endcase
   endfunction

   function automatic logic [7:0] lit_char(input logic [1:0] choice, input logic [2:0] pos);
      logic [39:0] row;
      unique case (choice)
         KIND_NULL:  row = {8'h00, 8'h6C, 8'h6C, 8'h75, 8'h6E};
         KIND_FALSE: row = {8'h65, 8'h73, 8'h6C, 8'h61, 8'h66};
         KIND_TRUE:  row = {8'h00, 8'h65, 8'h75, 8'h72, 8'h74};
         default:    row = 40'h0;
      endcase
      unique case (pos)
         3'd0:    lit_char = row[7:0];
         3'd1:    lit_char = row[15:8];
         3'd2:    lit_char = row[23:16];
         3'd3:    lit_char = row[31:24];
         3'd4:    lit_char = row[39:32];
         default: lit_char = 8'h00;
      endcase
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      is_space = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

endpackage

// File: rtl/jsv_step.sv
// Next-state and verdict logic for one text word of the validator.
// Depends on jsv_pkg for the state record, codes and literal tables.
module jsv_step
   import jsv_pkg::*;
(
   input  jsv_state_type  state_ff,
   input  logic [7:0]     text_byte,
   input  logic           end_of_text,
   output jsv_state_type  state_in,
   output jsv_result_type result
);

   jsv_state_type closed;
   jsv_state_type stepped;
   logic          digit;
   logic          exp_mark;
   logic          lit_ok;
   logic [2:0]    lit_next;

   assign digit    = is_digit(text_byte);
   assign exp_mark = (text_byte == CH_E_LO) || (text_byte == CH_E_UP);
   assign lit_next = state_ff.lit_pos + 3'd1;
   assign lit_ok   = (state_ff.lit_choice != 2'd3)
                   && (state_ff.lit_pos < lit_len(state_ff.lit_choice))
                   && (lit_char(state_ff.lit_choice, state_ff.lit_pos) == text_byte);

   always_comb begin
      closed       = state_ff;
      closed.phase = PH_TRAIL;
      unique case (state_ff.phase)
         PH_LIT_DONE: begin
            closed.status = ST_OK;
            closed.kind   = state_ff.lit_choice;
         end
         PH_ZERO, PH_INT, PH_FRAC, PH_EXP_DIG: begin
            closed.status = ST_OK;
            closed.kind   = KIND_NUMBER;
         end
         PH_DECIDED, PH_TRAIL: begin
         end
         default: begin
            closed.status = ST_INVALID;
            closed.kind   = KIND_NULL;
         end
      endcase
   end

   always_comb begin
      stepped = state_ff;
      unique case (state_ff.phase)
         PH_LEAD: begin
            if (text_byte == CH_N || text_byte == CH_F || text_byte == CH_T) begin
               stepped.lit_choice = (text_byte == CH_N) ? KIND_NULL :
                                    (text_byte == CH_F) ? KIND_FALSE : KIND_TRUE;
               stepped.lit_pos    = 3'd1;
               stepped.phase      = PH_LIT;
            end else if (text_byte == CH_MINUS) begin
               stepped.phase = PH_SIGN;
            end else if (text_byte == CH_ZERO) begin
               stepped.phase = PH_ZERO;
            end else if (digit) begin
               stepped.phase = PH_INT;
            end else begin
               stepped.phase  = PH_DECIDED;
               stepped.status = ST_INVALID;
               stepped.kind   = KIND_NULL;
            end
         end
         PH_LIT: begin
            if (!lit_ok) begin
               stepped.phase  = PH_DECIDED;
               stepped.status = ST_INVALID;
               stepped.kind   = KIND_NULL;
            end else begin
               stepped.lit_pos = lit_next;
               if (lit_next == lit_len(state_ff.lit_choice)) stepped.phase = PH_LIT_DONE;
            end
         end
         PH_LIT_DONE: begin
            stepped.phase  = PH_DECIDED;
            stepped.status = ST_NOT_SINGULAR;
            stepped.kind   = KIND_NULL;
         end
         PH_SIGN: begin
            if (text_byte == CH_ZERO) begin
               stepped.phase = PH_ZERO;
            end else if (digit) begin
               stepped.phase = PH_INT;
            end else begin
               stepped.phase  = PH_DECIDED;
               stepped.status = ST_INVALID;
               stepped.kind   = KIND_NULL;
            end
         end
         PH_ZERO, PH_INT: begin
            if (text_byte == CH_DOT) begin
               stepped.phase = PH_DOT;
            end else if (exp_mark) begin
               stepped.phase = PH_EXP;
            end else if (state_ff.phase == PH_INT && digit) begin
               stepped.phase = PH_INT;
            end else begin
               stepped.phase  = PH_DECIDED;
               stepped.status = ST_NOT_SINGULAR;
               stepped.kind   = KIND_NULL;
            end
         end
         PH_DOT: begin
            if (digit) begin
               stepped.phase = PH_FRAC;
            end else begin
               stepped.phase  = PH_DECIDED;
               stepped.status = ST_INVALID;
               stepped.kind   = KIND_NULL;
            end
         end
         PH_FRAC: begin
            if (digit) begin
               stepped.phase = PH_FRAC;
            end else if (exp_mark) begin
               stepped.phase = PH_EXP;
            end else begin
               stepped.phase  = PH_DECIDED;
               stepped.status = ST_NOT_SINGULAR;
               stepped.kind   = KIND_NULL;
            end
         end
         PH_EXP: begin
            if (text_byte == CH_PLUS || text_byte == CH_MINUS) begin
               stepped.phase = PH_EXP_SIGN;
            end else if (digit) begin
               stepped.phase = PH_EXP_DIG;
            end else begin
               stepped.phase  = PH_DECIDED;
               stepped.status = ST_INVALID;
               stepped.kind   = KIND_NULL;
            end
         end
         PH_EXP_SIGN: begin
            if (digit) begin
               stepped.phase = PH_EXP_DIG;
            end else begin
               stepped.phase  = PH_DECIDED;
               stepped.status = ST_INVALID;
               stepped.kind   = KIND_NULL;
            end
         end
         PH_EXP_DIG: begin
            if (!digit) begin
               stepped.phase  = PH_DECIDED;
               stepped.status = ST_NOT_SINGULAR;
               stepped.kind   = KIND_NULL;
            end
         end
         PH_TRAIL: begin
            stepped.second_seen = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      result.valid  = end_of_text;
      result.status = ST_OK;
      result.kind   = KIND_NULL;
      if (end_of_text) begin
         state_in = JSV_STATE_RESET;
         if (state_ff.second_seen) begin
            result.status = ST_NOT_SINGULAR;
         end else if (state_ff.phase == PH_LEAD) begin
            result.status = ST_EXPECT;
         end else begin
            result.status = closed.status;
            if (closed.status == ST_OK) result.kind = closed.kind;
         end
      end else if (is_space(text_byte)) begin
         if (state_ff.phase != PH_LEAD && state_ff.phase != PH_TRAIL) state_in = closed;
      end else begin
         state_in = stepped;
      end
   end

endmodule

// File: rtl/json_scalar_validator.sv
// Top level of the JSON scalar validator: input register, parse state, result register.
// Depends on jsv_pkg and jsv_step.
//
//   channel | ports                                   | role
//   req     | req_valid req_ready req_text_byte        | one text word per handshake
//           | req_end_of_text                         |
//   rsp     | rsp_valid rsp_ready rsp_parse_status     | one verdict per end-of-text word
//           | rsp_value_kind                          |
//
// One word per cycle while no result stalls: the input register feeds the state update in jsv_step.
// The verdict of an end-of-text word passes through the input register and then the result register.
// Reset returns the parse state to leading whitespace and empties both registers.
// A stalled result holds an end-of-text word in the input register; other words go on.
module json_scalar_validator
   import jsv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_text_byte,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_parse_status,
   output logic [1:0] rsp_value_kind
);

   logic           s1_valid_ff;
   logic [7:0]     s1_byte_ff;
   logic           s1_end_ff;
   jsv_state_type  state_ff;
   jsv_state_type  state_in;
   jsv_result_type result;
   logic           rsp_valid_ff;
   jsv_status_type rsp_status_ff;
   logic [1:0]     rsp_kind_ff;
   logic           out_free;
   logic           consume;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign consume   = s1_valid_ff && (!s1_end_ff || out_free);
   assign req_ready = !s1_valid_ff || consume;

   jsv_step u_step (
      .state_ff    (state_ff),
      .text_byte   (s1_byte_ff),
      .end_of_text (s1_end_ff),
      .state_in    (state_in),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_byte_ff <= req_text_byte;
         s1_end_ff  <= req_end_of_text;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= JSV_STATE_RESET;
      end else if (consume) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (consume && result.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (consume && result.valid) begin
         rsp_status_ff <= result.status;
         rsp_kind_ff   <= result.kind;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_parse_status = rsp_status_ff;
   assign rsp_value_kind   = rsp_kind_ff;

   a_kind_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != ST_OK) |-> (rsp_kind_ff == KIND_NULL))
      else $error("value kind set on a failed verdict");

   a_end_resets: assert property (@(posedge clock) disable iff (reset)
      consume && s1_end_ff |=> (state_ff == JSV_STATE_RESET))
      else $error("parse state not cleared after end of text");

   a_second_in_trail: assert property (@(posedge clock) disable iff (reset)
      state_ff.second_seen |-> (state_ff.phase == PH_TRAIL))
      else $error("second token flagged outside trailing phase");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_end_ff && rsp_valid_ff && !rsp_ready |-> !req_ready)
      else $error("input taken while a verdict is blocked");

endmodule
